// File: design/sap_pkg.sv
`timescale 1ns / 1ps

package sap_pkg;

    localparam int MAX_BOXES_DEF  = 16;
    localparam int COORD_BITS_DEF = 16;

    localparam int INDEX_W = 4;
    localparam int MASK_W  = 16;
    localparam int AXIS_W  = 2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic start;
        logic clear;
    } stats_ctrl_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [AXIS_W-1:0] axis;
    } stats_stat_t;

endpackage

// File: design/sap_ifs.sv
`timescale 1ns / 1ps

interface sap_box_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] lo_x;
    logic signed [COORD_BITS-1:0] lo_y;
    logic signed [COORD_BITS-1:0] lo_z;
    logic signed [COORD_BITS-1:0] hi_x;
    logic signed [COORD_BITS-1:0] hi_y;
    logic signed [COORD_BITS-1:0] hi_z;
    logic                         final_box;

    modport source
    (
        output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, final_box,
        input  ready
    );
    modport sink
    (
        input  valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, final_box,
        output ready
    );
endinterface

interface sap_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  box_index;
    logic [15:0] partner_mask;
    logic [1:0]  axis_used;
    logic [1:0]  axis_next;
    logic        final_result;

    modport source
    (
        output valid, box_index, partner_mask, axis_used, axis_next, final_result,
        input  ready
    );
    modport sink
    (
        input  valid, box_index, partner_mask, axis_used, axis_next, final_result,
        output ready
    );
endinterface

// File: design/sweep_and_prune_box_overlap_top.sv
`timescale 1ns / 1ps
// Loading: one box transfer per cycle while idle, stored in the box memory up to MAX_BOXES.
// After the final box: the centre pipeline drains, the axis pick runs, then each box is
// compared in turn (one box memory read per cycle against all n boxes) and its result emitted.
// Reset: asynchronous, active low; clears count, sweep axis (x) and centre sums.
module sweep_and_prune_box_overlap_top import sap_pkg::*; #(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    sap_box_if.sink      boxes,
    sap_res_if.source    results
);

    localparam int CB    = COORD_BITS;
    localparam int AW    = $clog2(MAX_BOXES);
    localparam int CW    = $clog2(MAX_BOXES + 1);
    localparam int BW    = 6 * CB;
    localparam int MASKW = (MAX_BOXES > MASK_W) ? MAX_BOXES : MASK_W;
    localparam int IXW   = (AW > INDEX_W) ? AW : INDEX_W;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DRAIN = 7'b0000010,
        ST_AXIS  = 7'b0000100,
        ST_LDA   = 7'b0001000,
        ST_LDB   = 7'b0010000,
        ST_SCAN  = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t             state_reg,     state_next;
    logic [CW-1:0]      count_reg,     count_next;
    logic [AXIS_W-1:0]  axis_reg,      axis_next;
    logic [AXIS_W-1:0]  nxt_axis_reg,  nxt_axis_next;
    logic [AW-1:0]      a_reg,         a_next;
    logic [CW-1:0]      j_reg,         j_next;
    logic               rv_reg,        rv_next;
    logic [AW-1:0]      ridx_reg,      ridx_next;
    logic [BW-1:0]      abox_reg,      abox_next;
    logic [MASKW-1:0]   mask_reg,      mask_next;
    logic               ov_reg,        ov_next;
    logic               load_out;
    logic [INDEX_W-1:0] oidx_reg;
    logic [MASK_W-1:0]  omask_reg;
    logic [AXIS_W-1:0]  oused_reg;
    logic [AXIS_W-1:0]  onext_reg;
    logic               ofinal_reg;

    logic               in_xfer;
    logic               store;
    logic [BW-1:0]      wdata;
    logic [AW-1:0]      raddr;
    logic [BW-1:0]      rdata;
    logic               last_box;
    logic [IXW-1:0]     a_ext;
    stats_ctrl_t        sctrl;
    stats_stat_t        sstat;

    logic signed [CB-1:0] lo_a [3];
    logic signed [CB-1:0] hi_a [3];
    logic signed [CB-1:0] lo_b [3];
    logic signed [CB-1:0] hi_b [3];
    logic signed [CB-1:0] lo_a_ax, hi_a_ax, lo_b_ax;
    logic                 touch, later, hit;

    assign boxes.ready = (state_reg == ST_IDLE);
    assign in_xfer     = boxes.valid && boxes.ready;
    assign store       = in_xfer && (count_reg < CW'(MAX_BOXES));
    assign wdata       = {boxes.hi_z, boxes.hi_y, boxes.hi_x,
                          boxes.lo_z, boxes.lo_y, boxes.lo_x};
    assign raddr       = (state_reg == ST_LDA) ? a_reg : j_reg[AW-1:0];
    assign last_box    = (CW'(a_reg) + CW'(1)) == count_reg;
    assign a_ext       = IXW'(a_reg);

    sap_box_ram #(
        .DEPTH (MAX_BOXES),
        .WIDTH (BW)
    ) u_ram (
        .clk   (clk),
        .we    (store),
        .waddr (count_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    sap_stats #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (store),
        .box    (wdata),
        .n      (count_reg),
        .ctrl   (sctrl),
        .stat   (sstat)
    );

    // pair test of box a against the box read last cycle
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo_a[k] = $signed(abox_reg[k*CB +: CB]);
            hi_a[k] = $signed(abox_reg[(3+k)*CB +: CB]);
            lo_b[k] = $signed(rdata[k*CB +: CB]);
            hi_b[k] = $signed(rdata[(3+k)*CB +: CB]);
        end
        touch = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            if (lo_a[k] > hi_b[k] || lo_b[k] > hi_a[k])
            begin
                touch = 1'b0;
            end
        end
        case (axis_reg)
            AXIS_Y:
            begin
                lo_a_ax = lo_a[1];
                hi_a_ax = hi_a[1];
                lo_b_ax = lo_b[1];
            end
            AXIS_Z:
            begin
                lo_a_ax = lo_a[2];
                hi_a_ax = hi_a[2];
                lo_b_ax = lo_b[2];
            end
            default:
            begin
                lo_a_ax = lo_a[0];
                hi_a_ax = hi_a[0];
                lo_b_ax = lo_b[0];
            end
        endcase
        // b sorts after a: larger minimum, or equal minimum and later load index
        later = (lo_b_ax > lo_a_ax) || (lo_b_ax == lo_a_ax && ridx_reg > a_reg);
        hit   = later && (lo_b_ax < hi_a_ax) && touch;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        axis_next     = axis_reg;
        nxt_axis_next = nxt_axis_reg;
        a_next        = a_reg;
        j_next        = j_reg;
        rv_next       = 1'b0;
        ridx_next     = ridx_reg;
        abox_next     = abox_reg;
        mask_next     = mask_reg;
        ov_next       = ov_reg && !results.ready;
        load_out      = 1'b0;
        sctrl         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (store)
                begin
                    count_next = count_reg + CW'(1);
                end
                if (in_xfer && boxes.final_box)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sstat.busy)
                begin
                    sctrl.start = 1'b1;
                    state_next  = ST_AXIS;
                end
            end
            ST_AXIS:
            begin
                if (sstat.done)
                begin
                    nxt_axis_next = sstat.axis;
                    sctrl.clear   = 1'b1;
                    a_next        = '0;
                    state_next    = ST_LDA;
                end
            end
            ST_LDA:
            begin
                state_next = ST_LDB;
            end
            ST_LDB:
            begin
                abox_next  = rdata;
                j_next     = '0;
                mask_next  = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (j_reg < count_reg)
                begin
                    rv_next   = 1'b1;
                    ridx_next = j_reg[AW-1:0];
                    j_next    = j_reg + CW'(1);
                end
                if (rv_reg && hit)
                begin
                    mask_next[ridx_reg] = 1'b1;
                end
                if (j_reg == count_reg && !rv_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!ov_reg || results.ready)
                begin
                    load_out = 1'b1;
                    ov_next  = 1'b1;
                    if (last_box)
                    begin
                        axis_next  = nxt_axis_reg;
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        a_next     = a_reg + AW'(1);
                        state_next = ST_LDA;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            axis_reg     <= AXIS_X;
            nxt_axis_reg <= AXIS_X;
            a_reg        <= '0;
            j_reg        <= '0;
            rv_reg       <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            axis_reg     <= axis_next;
            nxt_axis_reg <= nxt_axis_next;
            a_reg        <= a_next;
            j_reg        <= j_next;
            rv_reg       <= rv_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= ridx_next;
        abox_reg <= abox_next;
        mask_reg <= mask_next;
        if (load_out)
        begin
            oidx_reg   <= a_ext[INDEX_W-1:0];
            omask_reg  <= mask_reg[MASK_W-1:0];
            oused_reg  <= axis_reg;
            onext_reg  <= nxt_axis_reg;
            ofinal_reg <= last_box;
        end
    end

    assign results.valid        = ov_reg;
    assign results.box_index    = oidx_reg;
    assign results.partner_mask = omask_reg;
    assign results.axis_used    = oused_reg;
    assign results.axis_next    = onext_reg;
    assign results.final_result = ofinal_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_BOXES))
        else $error("box count above capacity");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (count_reg != '0))
        else $error("sweep with empty set");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_IDLE)
            |=> (results.valid && results.final_result))
        else $error("last result of run not flagged");

    a_axis_code: assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg == AXIS_X || axis_reg == AXIS_Y || axis_reg == AXIS_Z)
        else $error("sweep axis code invalid");

endmodule

// File: design/sap_box_ram.sv
`timescale 1ns / 1ps

module sap_box_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 96
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/sap_stats.sv
`timescale 1ns / 1ps

module sap_stats import sap_pkg::*; #(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample,
    input  logic [6*COORD_BITS-1:0]            box,
    input  logic [$clog2(MAX_BOXES+1)-1:0]     n,
    input  stats_ctrl_t                        ctrl,
    output stats_stat_t                        stat
);

    localparam int CB  = COORD_BITS;
    localparam int CW  = $clog2(MAX_BOXES + 1);
    localparam int SW  = CB + 1 + CW;
    localparam int SQW = 2 * CB + 2 + CW;
    localparam int P   = SQW + CW;

    logic                    v1_reg;
    logic                    v2_reg;
    logic signed [CB:0]      d_reg     [3];
    logic signed [CB:0]      d2_reg    [3];
    logic [2*CB+1:0]         sq_reg    [3];
    logic signed [SW-1:0]    sum_reg   [3];
    logic [SQW-1:0]          sqsum_reg [3];

    logic                    run_reg;
    logic                    ph_reg;
    logic [1:0]              k_reg;
    logic [P-1:0]            p1_reg;
    logic [P-1:0]            p2_reg;
    logic signed [P:0]       best_reg;
    logic [AXIS_W-1:0]       best_axis_reg;
    logic                    done_reg;

    logic signed [SW-1:0]    sum_sel;
    logic [SQW-1:0]          sqsum_sel;
    logic signed [P:0]       score;

    assign sum_sel   = sum_reg[k_reg];
    assign sqsum_sel = sqsum_reg[k_reg];
    assign score     = $signed({1'b0, p1_reg}) - $signed({1'b0, p2_reg});

    // centre pipeline: doubled centre, square, accumulate
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_reg[k]  <= $signed({box[k*CB+CB-1], box[k*CB +: CB]})
                       + $signed({box[(3+k)*CB+CB-1], box[(3+k)*CB +: CB]});
            d2_reg[k] <= d_reg[k];
            sq_reg[k] <= $unsigned((2*CB+2)'(d_reg[k]) * (2*CB+2)'(d_reg[k]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k]   <= '0;
                sqsum_reg[k] <= '0;
            end
        end
        else
        begin
            v1_reg <= sample;
            v2_reg <= v1_reg;
            for (int k = 0; k < 3; k++)
            begin
                if (ctrl.clear)
                begin
                    sum_reg[k]   <= '0;
                    sqsum_reg[k] <= '0;
                end
                else if (v2_reg)
                begin
                    sum_reg[k]   <= sum_reg[k] + SW'(d2_reg[k]);
                    sqsum_reg[k] <= sqsum_reg[k] + SQW'(sq_reg[k]);
                end
            end
        end
    end

    // score = n * sum(d*d) - (sum d)^2, axes x, y, z in turn: products, then compare
    always_ff @(posedge clk)
    begin
        if (run_reg && !ph_reg)
        begin
            p1_reg <= P'(n) * P'(sqsum_sel);
            p2_reg <= $unsigned(P'(sum_sel) * P'(sum_sel));
        end
        if (run_reg && ph_reg && (k_reg == 2'd0 || score > best_reg))
        begin
            best_reg <= score;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            ph_reg        <= 1'b0;
            k_reg         <= '0;
            best_axis_reg <= AXIS_X;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                run_reg <= 1'b1;
                ph_reg  <= 1'b0;
                k_reg   <= '0;
            end
            else if (run_reg)
            begin
                ph_reg <= !ph_reg;
                if (ph_reg)
                begin
                    if (k_reg == 2'd0 || score > best_reg)
                    begin
                        best_axis_reg <= k_reg;
                    end
                    if (k_reg == 2'd2)
                    begin
                        run_reg  <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
            end
        end
    end

    assign stat.busy = v1_reg | v2_reg;
    assign stat.done = done_reg;
    assign stat.axis = best_axis_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("axis done held longer than one cycle");

    a_start_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !(v1_reg || v2_reg))
        else $error("axis pick started with centre pipeline busy");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> k_reg != 2'd3)
        else $error("axis counter out of range");

endmodule

// File: tb/sv/tb_sweep_and_prune_box_overlap_top.sv
`timescale 1ns / 1ps

module tb_sweep_and_prune_box_overlap_top;
    import sap_pkg::*;

    localparam int NB = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
        logic               final_box;
    } box_t;

    typedef struct packed {
        logic [3:0]  box_index;
        logic [15:0] partner_mask;
        logic [1:0]  axis_used;
        logic [1:0]  axis_next;
        logic        final_result;
    } overlap_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors = 0;
    int   idle_cycles = 0;

    sap_box_if #(.COORD_BITS(16)) boxes ();
    sap_res_if results ();

    sweep_and_prune_box_overlap_top DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .boxes   (boxes.sink),
        .results (results.source)
    );

    always #10 clk = ~clk;

    // model state
    logic signed [15:0] held_lo[NB][3];
    logic signed [15:0] held_hi[NB][3];
    int                 held_count = 0;
    logic [1:0]         cur_axis = AXIS_X;
    overlap_res_t       pending_overlaps[$];

    function automatic logic [1:0] widest_axis();
        logic signed [63:0] s, q, score, best;
        logic signed [16:0] d;
        logic [1:0]         ax;
        begin
            best = 0;
            ax = AXIS_X;
            for (int k = 0; k < 3; k++)
            begin
                s = 0;
                q = 0;
                for (int i = 0; i < held_count; i++)
                begin
                    d = 17'(held_lo[i][k]) + 17'(held_hi[i][k]);
                    s += d;
                    q += d * d;
                end
                score = held_count * q - s * s;
                if (k == 0 || score > best)
                begin
                    best = score;
                    ax = 2'(k);
                end
            end
            return ax;
        end
    endfunction

    function automatic bit boxes_meet(int a, int b);
        for (int k = 0; k < 3; k++)
            if (held_lo[a][k] > held_hi[b][k] || held_lo[b][k] > held_hi[a][k])
                return 0;
        return 1;
    endfunction

    task automatic predict_box(box_t b);
        int order[NB];
        int j, cur, a, c;
        logic [15:0] masks[NB];
        logic [1:0]  nxt;
        overlap_res_t r;
        begin
            if (held_count < NB)
            begin
                held_lo[held_count] = '{b.lo_x, b.lo_y, b.lo_z};
                held_hi[held_count] = '{b.hi_x, b.hi_y, b.hi_z};
                held_count++;
            end
            if (b.final_box)
            begin
                for (int i = 0; i < held_count; i++)
                begin
                    cur = i;
                    j = i;
                    while (j > 0 && held_lo[order[j-1]][cur_axis] > held_lo[cur][cur_axis])
                    begin
                        order[j] = order[j-1];
                        j--;
                    end
                    order[j] = cur;
                    masks[i] = '0;
                end
                for (int i = 0; i + 1 < held_count; i++)
                begin
                    a = order[i];
                    for (int m = i + 1; m < held_count; m++)
                    begin
                        c = order[m];
                        if (!(held_lo[c][cur_axis] < held_hi[a][cur_axis]))
                            break;
                        if (boxes_meet(a, c))
                            masks[a][c] = 1'b1;
                    end
                end
                nxt = widest_axis();
                for (int i = 0; i < held_count; i++)
                begin
                    r.box_index = 4'(i);
                    r.partner_mask = masks[i];
                    r.axis_used = cur_axis;
                    r.axis_next = nxt;
                    r.final_result = (i + 1 == held_count);
                    pending_overlaps.push_back(r);
                end
                cur_axis = nxt;
                held_count = 0;
            end
        end
    endtask

    // valid stays high into the next item when no gap is drawn
    task automatic send_box(box_t b);
        int gap;
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            if (gap != 0)
            begin
                boxes.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            boxes.valid <= 1'b1;
            {boxes.lo_x, boxes.lo_y, boxes.lo_z, boxes.hi_x, boxes.hi_y, boxes.hi_z,
             boxes.final_box} <= b;
            @(posedge clk);
            while (!boxes.ready) @(posedge clk);
            predict_box(b);
        end
    endtask

    task automatic wait_drained();
        boxes.valid <= 1'b0;
        while (pending_overlaps.size() != 0) @(posedge clk);
    endtask

    function automatic box_t rand_box(bit fin, int span);
        box_t b;
        logic signed [15:0] c, w;
        begin
            for (int k = 0; k < 3; k++)
            begin
                c = 16'($urandom_range(0, 2 * span) - span);
                w = 16'($urandom_range(0, span / 2));
                if (k == 0) begin b.lo_x = c - w; b.hi_x = c + w; end
                if (k == 1) begin b.lo_y = c - w; b.hi_y = c + w; end
                if (k == 2) begin b.lo_z = c - w; b.hi_z = c + w; end
            end
            b.final_box = fin;
            return b;
        end
    endfunction

    task automatic test_directed();
        box_t b;
        begin
            // extremes, overlapping full-range pair
            b = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0};
            send_box(b);
            send_box(b);
            // inverted box
            b = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0};
            send_box(b);
            // touching on faces
            b = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0010, 16'sh0010, 16'sh0010, 1'b0};
            send_box(b);
            b = '{16'sh0010, 16'sh0000, 16'sh0000, 16'sh0020, 16'sh0010, 16'sh0010, 1'b0};
            send_box(b);
            b = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0010, 16'sh0010, 16'sh0010, 1'b1};
            send_box(b);
            wait_drained();
            // two-box set, spread on y
            send_box('{16'sh0000, 16'sh1000, 16'sh0000, 16'sh0001, 16'sh2000, 16'sh0001, 1'b0});
            send_box('{16'sh0000, -16'sh2000, 16'sh0000, 16'sh0001, -16'sh1000, 16'sh0001, 1'b1});
            wait_drained();
            send_box(rand_box(1'b1, 100));
            wait_drained();
        end
    endtask

    task automatic test_overflow();
        // set full: 17th box dropped, final carried by dropped box
        for (int i = 0; i < NB; i++)
            send_box(rand_box(1'b0, 2000));
        send_box(rand_box(1'b1, 2000));
        wait_drained();
        for (int i = 0; i < NB + 2; i++)
            send_box(rand_box(i == NB + 1, 30000));
    endtask

    task automatic test_random();
        int n;
        box_t b;
        begin
            for (int s = 0; s < 28; s++)
            begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                begin
                    b = rand_box(i == n - 1, $urandom_range(0, 1) ? 200 : 32000);
                    if ($urandom_range(0, 9) == 0)
                        b[96:1] = {$urandom, $urandom, $urandom};
                    send_box(b);
                end
                if (s == 10)
                    wait_drained();
            end
        end
    endtask

    // result checking and receiver stalls
    initial
    begin
        overlap_res_t got, exp_r;
        int stall;
        results.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            if (stall != 0)
            begin
                results.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results.ready <= 1'b1;
            @(posedge clk);
            while (!results.valid) @(posedge clk);
            got = {results.box_index, results.partner_mask, results.axis_used,
                   results.axis_next, results.final_result};
            if (pending_overlaps.size() == 0)
            begin
                $display("%0t unexpected result expected none actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_r = pending_overlaps.pop_front();
                if (got.box_index != exp_r.box_index)
                    begin $display("%0t box_index expected %0d actual %0d", $time,
                        exp_r.box_index, got.box_index); errors++; end
                if (got.partner_mask != exp_r.partner_mask)
                    begin $display("%0t partner_mask expected %h actual %h", $time,
                        exp_r.partner_mask, got.partner_mask); errors++; end
                if (got.axis_used != exp_r.axis_used)
                    begin $display("%0t axis_used expected %0d actual %0d", $time,
                        exp_r.axis_used, got.axis_used); errors++; end
                if (got.axis_next != exp_r.axis_next)
                    begin $display("%0t axis_next expected %0d actual %0d", $time,
                        exp_r.axis_next, got.axis_next); errors++; end
                if (got.final_result != exp_r.final_result)
                    begin $display("%0t final_result expected %0d actual %0d", $time,
                        exp_r.final_result, got.final_result); errors++; end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((boxes.valid && boxes.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sweep_and_prune_box_overlap_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        boxes.valid = 1'b0;
        {boxes.lo_x, boxes.lo_y, boxes.lo_z, boxes.hi_x, boxes.hi_y, boxes.hi_z,
         boxes.final_box} = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_random();
        wait_drained();
        repeat (400) @(posedge clk);
        if (errors == 0 && pending_overlaps.size() == 0)
            $display("sweep_and_prune_box_overlap_top: match");
        else
            $display("sweep_and_prune_box_overlap_top: mismatch");
        $finish;
    end
endmodule

// File: files.f
design/sap_pkg.sv
design/sap_ifs.sv
design/sap_box_ram.sv
design/sap_stats.sv
design/sweep_and_prune_box_overlap_top.sv
tb/sv/tb_sweep_and_prune_box_overlap_top.sv
